### rtl/srtp_pkg.sv
package srtp_pkg;

  localparam int MASK_W = 16;
  localparam int THREAD_W = 4;
  localparam int CNT_W = 5;
  localparam int RAND_W = 31;
  localparam int CHANCE_W = 16;
  localparam int DIVD_W = 32;
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES = DIVD_W / STEPS_PER_STAGE;

  typedef enum logic {
    OP_SCHEDULE = 1'b0,
    OP_SIGNAL   = 1'b1
  } pick_op_e;

  typedef struct packed {
    logic                keep_ok;
    logic [THREAD_W-1:0] cur;
    logic [MASK_W-1:0]   mask;
    logic [CNT_W-1:0]    cnt;
    logic [DIVD_W-1:0]   keep_divd;
    logic [CHANCE_W-1:0] keep_rem;
    logic [DIVD_W-1:0]   pick_divd;
    logic [CNT_W-1:0]    pick_rem;
  } stage_t;

  function automatic logic [CHANCE_W-1:0] keep_step(input logic [CHANCE_W-1:0] rem,
                                                    input logic bit_in,
                                                    input logic [CHANCE_W-1:0] div);
    logic [CHANCE_W:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, div}) begin
      t = t - {1'b0, div};
    end
    return t[CHANCE_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] pick_step(input logic [CNT_W-1:0] rem,
                                                 input logic bit_in,
                                                 input logic [CNT_W-1:0] div);
    logic [CNT_W:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, div}) begin
      t = t - {1'b0, div};
    end
    return t[CNT_W-1:0];
  endfunction

endpackage

### rtl/sticky_random_thread_picker.sv
// Random thread arbiter with a sticky running thread. It takes one transaction per
// clock while the output side is not stalled and returns one result per transaction;
// stalls back up through the stages without losing a transaction, and empty stages
// are filled while the output waits. The pipeline depth is set by the remainders:
// both remainders (rand_keep by keep_chance and rand_pick by the candidate count)
// are formed four dividend bits per stage over eight stages, with one input stage
// before and the output register after.
// Only mask bits below MAX_THREADS take part, and a running thread at or above
// MAX_THREADS is never kept. A keep_chance of zero acts as one.
module sticky_random_thread_picker
  import srtp_pkg::*;
#(
  parameter int MAX_THREADS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // thread_mask [15:0], current_thread [19:16], rand_keep [50:20], rand_pick [81:51]
  input  logic [87:0] s_axis_tdata,
  // opcode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // chosen_thread [3:0]
  output logic [7:0]  m_axis_tdata,
  // found
  output logic        m_axis_tuser
);

  logic [CHANCE_W-1:0] keep_chance_q;
  logic [CHANCE_W-1:0] div_keep;

  stage_t st_q [0:DIV_STAGES];
  stage_t st_d [0:DIV_STAGES];
  logic   vld_q [0:DIV_STAGES];
  logic   vld_in [0:DIV_STAGES];
  logic   rdy [0:DIV_STAGES];
  logic   rdy_out;

  logic [MASK_W-1:0]   mask_use;
  logic [THREAD_W-1:0] cur_in;
  logic                cur_ok;

  logic [MASK_W-1:0]   hit;
  logic [THREAD_W-1:0] pick_idx;
  logic                keep_fin;
  logic                found_d;
  logic [THREAD_W-1:0] chosen_d;

  logic                out_vld_q;
  logic                found_q;
  logic [THREAD_W-1:0] chosen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_chance_q <= CHANCE_W'(1);
    end else if (cfg_we_i) begin
      keep_chance_q <= cfg_wdata_i;
    end
  end

  assign div_keep = (keep_chance_q == '0) ? CHANCE_W'(1) : keep_chance_q;

  for (genvar i = 0; i < MASK_W; i++) begin : g_mask
    assign mask_use[i] = (i < MAX_THREADS) ? s_axis_tdata[i] : 1'b0;
  end

  assign cur_in = s_axis_tdata[MASK_W+THREAD_W-1:MASK_W];
  assign cur_ok = ({{(32-THREAD_W){1'b0}}, cur_in} < 32'(MAX_THREADS));

  always_comb begin
    st_d[0].keep_ok   = (s_axis_tuser == OP_SCHEDULE) && cur_ok && mask_use[cur_in];
    st_d[0].cur       = cur_in;
    st_d[0].mask      = mask_use;
    st_d[0].cnt       = CNT_W'($countones(mask_use));
    st_d[0].keep_divd = {1'b0, s_axis_tdata[MASK_W+THREAD_W+RAND_W-1:MASK_W+THREAD_W]};
    st_d[0].keep_rem  = '0;
    st_d[0].pick_divd = {1'b0, s_axis_tdata[MASK_W+THREAD_W+2*RAND_W-1:
                                            MASK_W+THREAD_W+RAND_W]};
    st_d[0].pick_rem  = '0;
    for (int s = 1; s <= DIV_STAGES; s++) begin
      st_d[s] = st_q[s-1];
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        st_d[s].keep_rem  = keep_step(st_d[s].keep_rem, st_d[s].keep_divd[DIVD_W-1],
                                      div_keep);
        st_d[s].keep_divd = {st_d[s].keep_divd[DIVD_W-2:0], 1'b0};
        st_d[s].pick_rem  = pick_step(st_d[s].pick_rem, st_d[s].pick_divd[DIVD_W-1],
                                      (st_q[s-1].cnt == '0) ? CNT_W'(1) : st_q[s-1].cnt);
        st_d[s].pick_divd = {st_d[s].pick_divd[DIVD_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    rdy_out = m_axis_tready || !out_vld_q;
    rdy[DIV_STAGES] = !vld_q[DIV_STAGES] || rdy_out;
    for (int s = DIV_STAGES - 1; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
    vld_in[0] = s_axis_tvalid;
    for (int s = 1; s <= DIV_STAGES; s++) begin
      vld_in[s] = vld_q[s-1];
    end
  end

  assign s_axis_tready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
        if (rdy[s]) begin
          vld_q[s] <= vld_in[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s <= DIV_STAGES; s++) begin
      if (rdy[s] && vld_in[s]) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < MASK_W; i++) begin
      hit[i] = st_q[DIV_STAGES].mask[i] &&
               (CNT_W'($countones(st_q[DIV_STAGES].mask &
                                  MASK_W'((17'd1 << i) - 17'd1)))
                == st_q[DIV_STAGES].pick_rem);
      if (hit[i]) begin
        pick_idx = pick_idx | THREAD_W'(i);
      end
    end
    keep_fin = st_q[DIV_STAGES].keep_ok && (st_q[DIV_STAGES].keep_rem != '0);
    found_d  = keep_fin || (st_q[DIV_STAGES].cnt != '0);
    chosen_d = keep_fin ? st_q[DIV_STAGES].cur : pick_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rdy_out) begin
      out_vld_q <= vld_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out && vld_q[DIV_STAGES]) begin
      found_q  <= found_d;
      chosen_q <= chosen_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(8-THREAD_W){1'b0}}, chosen_q};
  assign m_axis_tuser  = found_q;

`ifndef SYNTHESIS
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !found_q |-> chosen_q == '0)
    else $error("Not-found result carries a nonzero thread.");

  a_pick_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DIV_STAGES] && st_q[DIV_STAGES].cnt != '0 |->
      st_q[DIV_STAGES].pick_rem < st_q[DIV_STAGES].cnt)
    else $error("Pick remainder is not below the candidate count.");

  a_keep_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DIV_STAGES] |-> st_q[DIV_STAGES].keep_rem < div_keep)
    else $error("Keep remainder is not below keep_chance.");

  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DIV_STAGES] && st_q[DIV_STAGES].cnt != '0 |-> $onehot(hit))
    else $error("Uniform choice does not select exactly one candidate.");
`endif

endmodule
